[rtl/mbdlp_pkg.sv]
package mbdlp_pkg;

    // number of buttons scanned in one word
    localparam int unsigned NUM_BUTTONS_DEF = 3;

    // width of the debounce and hold counters and of their thresholds
    localparam int unsigned CNT_W = 16;

    // register file
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = CNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS  = 2'd3;

    // register values after reset
    localparam logic             SCAN_ENABLE_RST       = 1'b0;
    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST    = 16'd50;
    localparam logic             LONG_PRESS_ENABLE_RST = 1'b1;
    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST  = 16'd1000;

    // settings shared by all lanes
    typedef struct packed {
        logic             scan_en;
        logic [CNT_W-1:0] db_ticks;
        logic             lp_en;
        logic [CNT_W-1:0] lp_ticks;
    } t_lane_cfg;

    // what one lane found for the current tick
    typedef struct packed {
        logic press;
        logic long_press;
        logic level;
    } t_lane_res;

endpackage

[rtl/multi_button_debounce_long_press.sv]
// Debouncer with long-press detection for a group of active-low buttons.
// Input channel: one word per scan tick, i_raw_levels bit i is the raw level
// of button i (0 = pressed), moved by i_in_valid / o_in_stall.
// Output channel: one word per input word on o_out_valid / i_out_stall with
// press pulses, long-press pulses and the debounced levels after that tick.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 scan enable, 1 debounce ticks, 2 long-press enable, 3 long-press ticks);
// write only while no word is in flight.
// Each button has its own lane with a debounce counter and a hold counter;
// all lanes update together, one word per cycle while o_in_stall is low.
// Each accepted word is registered in the output register or the skid stage.
// A two-entry output path (output register plus skid stage) lets a new word
// in while a finished one waits; o_in_stall rises only when both are full.
// At reset all buttons read released, counters are zero, scanning is off,
// debounce is 50 ticks, long press is on at 1000 ticks, outputs are empty.
module multi_button_debounce_long_press #(
    parameter int unsigned NUM_BUTTONS = mbdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [NUM_BUTTONS-1:0]           i_raw_levels,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [NUM_BUTTONS-1:0]           o_press_pulses,
    output logic [NUM_BUTTONS-1:0]           o_long_press_pulses,
    output logic [NUM_BUTTONS-1:0]           o_stable_levels,
    input  logic                             i_cfg_wr_en,
    input  logic [mbdlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbdlp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mbdlp_pkg::t_lane_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_en  <= mbdlp_pkg::SCAN_ENABLE_RST;
            r_cfg.db_ticks <= mbdlp_pkg::DEBOUNCE_TICKS_RST;
            r_cfg.lp_en    <= mbdlp_pkg::LONG_PRESS_ENABLE_RST;
            r_cfg.lp_ticks <= mbdlp_pkg::LONG_PRESS_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mbdlp_pkg::REG_SCAN_ENABLE: begin
                    r_cfg.scan_en <= i_cfg_data[0];
                end
                mbdlp_pkg::REG_DEBOUNCE_TICKS: begin
                    r_cfg.db_ticks <= i_cfg_data;
                end
                mbdlp_pkg::REG_LONG_PRESS_ENABLE: begin
                    r_cfg.lp_en <= i_cfg_data[0];
                end
                mbdlp_pkg::REG_LONG_PRESS_TICKS: begin
                    r_cfg.lp_ticks <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    logic                                   tick;
    mbdlp_pkg::t_lane_res [NUM_BUTTONS-1:0] lane_res;

    assign tick = i_in_valid && !o_in_stall;

    // one lane per button
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        mbdlp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tick  (tick),
            .i_raw   (i_raw_levels[g]),
            .i_cfg   (r_cfg),
            .o_res   (lane_res[g])
        );
    end

    // merge lane results and buffer the output word
    mbdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_tick              (tick),
        .i_lane_res          (lane_res),
        .o_in_stall          (o_in_stall),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_press_pulses      (o_press_pulses),
        .o_long_press_pulses (o_long_press_pulses),
        .o_stable_levels     (o_stable_levels)
    );

endmodule

[rtl/mbdlp_lane.sv]
module mbdlp_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_raw,
    input  mbdlp_pkg::t_lane_cfg i_cfg,
    output mbdlp_pkg::t_lane_res o_res
);

    localparam int unsigned W = mbdlp_pkg::CNT_W;

    logic         r_stable;
    logic [W-1:0] r_db_cnt;
    logic [W-1:0] r_hold_cnt;
    logic         r_reported;

    logic         n_stable;
    logic [W-1:0] n_db_cnt;
    logic [W-1:0] n_hold_cnt;
    logic         n_reported;

    logic [W:0]   db_inc;
    logic [W:0]   hold_inc;
    logic         press;
    logic         long_press;

    assign db_inc   = {1'b0, r_db_cnt} + {{W{1'b0}}, 1'b1};
    assign hold_inc = {1'b0, r_hold_cnt} + {{W{1'b0}}, 1'b1};

    // debounce and hold counting for one tick
    always_comb begin
        n_stable   = r_stable;
        n_db_cnt   = r_db_cnt;
        n_hold_cnt = r_hold_cnt;
        n_reported = r_reported;
        press      = 1'b0;
        long_press = 1'b0;
        if (i_cfg.scan_en) begin
            if (i_raw != r_stable) begin
                if (db_inc >= {1'b0, i_cfg.db_ticks}) begin
                    n_stable = i_raw;
                    n_db_cnt = '0;
                    if (!i_raw) begin
                        press = 1'b1;
                    end else begin
                        n_reported = 1'b0;
                        n_hold_cnt = '0;
                    end
                end else begin
                    n_db_cnt = db_inc[W-1:0];
                end
            end else begin
                n_db_cnt = '0;
            end

            // the held count only runs while stably pressed and not yet reported
            if (i_cfg.lp_en && !n_reported && !n_stable) begin
                if (hold_inc >= {1'b0, i_cfg.lp_ticks}) begin
                    n_hold_cnt = '0;
                    n_reported = 1'b1;
                    long_press = 1'b1;
                end else begin
                    n_hold_cnt = hold_inc[W-1:0];
                end
            end
        end
    end

    assign o_res.press      = press;
    assign o_res.long_press = long_press;
    assign o_res.level      = n_stable;

    // lane state, updated on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b1;
            r_db_cnt   <= '0;
            r_hold_cnt <= '0;
            r_reported <= 1'b0;
        end else if (i_tick) begin
            r_stable   <= n_stable;
            r_db_cnt   <= n_db_cnt;
            r_hold_cnt <= n_hold_cnt;
            r_reported <= n_reported;
        end
    end

endmodule

[rtl/mbdlp_merge.sv]
module mbdlp_merge #(
    parameter int unsigned NUM_BUTTONS = mbdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_tick,
    input  mbdlp_pkg::t_lane_res [NUM_BUTTONS-1:0] i_lane_res,
    output logic                                   o_in_stall,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [NUM_BUTTONS-1:0]                 o_press_pulses,
    output logic [NUM_BUTTONS-1:0]                 o_long_press_pulses,
    output logic [NUM_BUTTONS-1:0]                 o_stable_levels
);

    logic [NUM_BUTTONS-1:0] press_w;
    logic [NUM_BUTTONS-1:0] long_w;
    logic [NUM_BUTTONS-1:0] level_w;

    // gather lane results into one word
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_w[i] = i_lane_res[i].press;
            long_w[i]  = i_lane_res[i].long_press;
            level_w[i] = i_lane_res[i].level;
        end
    end

    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_out_press;
    logic [NUM_BUTTONS-1:0] r_out_long;
    logic [NUM_BUTTONS-1:0] r_out_level;
    logic                   r_skid_valid;
    logic [NUM_BUTTONS-1:0] r_skid_press;
    logic [NUM_BUTTONS-1:0] r_skid_long;
    logic [NUM_BUTTONS-1:0] r_skid_level;

    logic out_take;
    logic out_load_new;
    logic out_load_skid;
    logic skid_load;

    assign out_take      = r_out_valid && !i_out_stall;
    assign out_load_new  = i_tick && (!r_out_valid || out_take);
    assign skid_load     = i_tick && r_out_valid && !out_take;
    assign out_load_skid = !i_tick && out_take && r_skid_valid;

    // control of the output register and the skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_load_new || out_load_skid) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (skid_load) begin
                r_skid_valid <= 1'b1;
            end else if (out_load_skid) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    // payload of the output register and the skid stage
    always_ff @(posedge i_clk) begin
        if (out_load_new) begin
            r_out_press <= press_w;
            r_out_long  <= long_w;
            r_out_level <= level_w;
        end else if (out_load_skid) begin
            r_out_press <= r_skid_press;
            r_out_long  <= r_skid_long;
            r_out_level <= r_skid_level;
        end
        if (skid_load) begin
            r_skid_press <= press_w;
            r_skid_long  <= long_w;
            r_skid_level <= level_w;
        end
    end

    assign o_in_stall          = r_skid_valid;
    assign o_out_valid         = r_out_valid;
    assign o_press_pulses      = r_out_press;
    assign o_long_press_pulses = r_out_long;
    assign o_stable_levels     = r_out_level;

endmodule

[verif/multi_button_debounce_long_press_tb.sv]
module multi_button_debounce_long_press_tb;

    localparam int NB               = mbdlp_pkg::NUM_BUTTONS_DEF;
    localparam int RESET_CYCLES     = 12;
    localparam int HOLD_OFF_CYCLES  = 60;
    localparam int STALL_LIMIT      = 1000;
    localparam int PHASES           = 12;
    localparam int WORDS_PER_PHASE  = 94;
    localparam int SCAN_OFF_PHASE   = 4;
    localparam int HOLD_OFF_PHASE   = 2;

    // one tick worth of debouncer output
    typedef struct packed {
        logic [NB-1:0] press;
        logic [NB-1:0] long_press;
        logic [NB-1:0] levels;
    } t_tick_report;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // directed stimulus row: a config write or a scan word, optionally with a typed result
    typedef struct packed {
        t_row_kind                        kind;
        logic [mbdlp_pkg::CFG_IDX_W-1:0]  idx;
        logic [mbdlp_pkg::CFG_DATA_W-1:0] data;
        logic [NB-1:0]                    raw;
        logic                             pinned;
        t_tick_report                     report;
    } t_dir_row;

    localparam t_tick_report NO_REPORT = '0;
    localparam int DIR_ROWS = 29;

    // dut ports
    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [NB-1:0]                    i_raw_levels;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic [NB-1:0]                    o_press_pulses;
    logic [NB-1:0]                    o_long_press_pulses;
    logic [NB-1:0]                    o_stable_levels;
    logic                             i_cfg_wr_en;
    logic [mbdlp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mbdlp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // typed result that travels with the current word
    logic                  pin_valid;
    t_tick_report          pin_res;

    // debouncer state as the checker sees it
    logic [NB-1:0]         btn_level;
    int unsigned           db_cnt [NB];
    int unsigned           hold_cnt [NB];
    logic [NB-1:0]         lp_done;
    logic                  cfg_scan;
    int unsigned           cfg_db;
    logic                  cfg_lp_en;
    int unsigned           cfg_lp;

    t_tick_report          tick_reports_q [$];
    int                    words_sent    = 0;
    int                    results_seen  = 0;
    int                    fails         = 0;
    int                    cfg_writes    = 0;
    int                    press_count   = 0;
    int                    long_count    = 0;
    int                    hold_offs     = 0;
    int                    idle_cycles   = 0;
    bit                    hold_off_req  = 1'b0;
    bit                    quiet         = 1'b0;

    t_dir_row dir_tab [DIR_ROWS] = '{
        // scanning off after reset: nothing moves, all released
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b000, 1'b1, '{3'b000, 3'b000, 3'b111}},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b101, 1'b1, '{3'b000, 3'b000, 3'b111}},
        '{ROW_CFG, mbdlp_pkg::REG_SCAN_ENABLE, 16'd1, 3'b000, 1'b0, NO_REPORT},
        // zero thresholds act as one
        '{ROW_CFG, mbdlp_pkg::REG_DEBOUNCE_TICKS, 16'd0, 3'b000, 1'b0, NO_REPORT},
        '{ROW_CFG, mbdlp_pkg::REG_LONG_PRESS_TICKS, 16'd0, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b110, 1'b1, '{3'b001, 3'b001, 3'b110}},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b110, 1'b1, '{3'b000, 3'b000, 3'b110}},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b000, 1'b1, '{3'b110, 3'b110, 3'b000}},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b111, 1'b1, '{3'b000, 3'b000, 3'b111}},
        // short debounce, bounce back clears the count
        '{ROW_CFG, mbdlp_pkg::REG_DEBOUNCE_TICKS, 16'd3, 3'b000, 1'b0, NO_REPORT},
        '{ROW_CFG, mbdlp_pkg::REG_LONG_PRESS_TICKS, 16'd4, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b000, 1'b1, '{3'b000, 3'b000, 3'b111}},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b000, 1'b1, '{3'b000, 3'b000, 3'b111}},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b101, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b101, 1'b0, NO_REPORT},
        // long press off while held keeps the hold count
        '{ROW_CFG, mbdlp_pkg::REG_LONG_PRESS_ENABLE, 16'd0, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b101, 1'b0, NO_REPORT},
        '{ROW_CFG, mbdlp_pkg::REG_LONG_PRESS_ENABLE, 16'd1, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b101, 1'b0, NO_REPORT},
        // limit dropped below the running hold count
        '{ROW_CFG, mbdlp_pkg::REG_LONG_PRESS_TICKS, 16'd1, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b101, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b111, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b010, 1'b0, NO_REPORT},
        // largest thresholds
        '{ROW_CFG, mbdlp_pkg::REG_DEBOUNCE_TICKS, 16'hffff, 3'b000, 1'b0, NO_REPORT},
        '{ROW_CFG, mbdlp_pkg::REG_LONG_PRESS_TICKS, 16'hffff, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b111, 1'b0, NO_REPORT},
        '{ROW_CFG, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b000, 1'b0, NO_REPORT},
        '{ROW_WORD, mbdlp_pkg::REG_SCAN_ENABLE, 16'd0, 3'b010, 1'b0, NO_REPORT}
    };

    multi_button_debounce_long_press #(
        .NUM_BUTTONS(NB)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_raw_levels        (i_raw_levels),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_press_pulses      (o_press_pulses),
        .o_long_press_pulses (o_long_press_pulses),
        .o_stable_levels     (o_stable_levels),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // one scan tick through the debouncer state
    function automatic t_tick_report debounce_tick(input logic [NB-1:0] raw);
        t_tick_report rep;
        int b;
        rep = '0;
        for (b = 0; b < NB; b++) begin
            if (cfg_scan) begin
                if (raw[b] != btn_level[b]) begin
                    db_cnt[b]++;
                    if (db_cnt[b] >= cfg_db) begin
                        btn_level[b] = raw[b];
                        db_cnt[b] = 0;
                        if (!raw[b]) begin
                            rep.press[b] = 1'b1;
                        end else begin
                            hold_cnt[b] = 0;
                            lp_done[b] = 1'b0;
                        end
                    end
                end else begin
                    db_cnt[b] = 0;
                end
                // hold timer runs once per hold
                if (cfg_lp_en && !lp_done[b] && !btn_level[b]) begin
                    hold_cnt[b]++;
                    if (hold_cnt[b] >= cfg_lp) begin
                        hold_cnt[b] = 0;
                        lp_done[b] = 1'b1;
                        rep.long_press[b] = 1'b1;
                    end
                end
            end
            rep.levels[b] = btn_level[b];
        end
        return rep;
    endfunction

    // track config, predict accepted words, check returned words
    always @(posedge i_clk) begin : scoreboard
        t_tick_report want;
        int b;
        if (!i_rst_n) begin
            btn_level = '1;
            lp_done   = '0;
            for (b = 0; b < NB; b++) begin
                db_cnt[b]   = 0;
                hold_cnt[b] = 0;
            end
            cfg_scan  = mbdlp_pkg::SCAN_ENABLE_RST;
            cfg_db    = 32'(mbdlp_pkg::DEBOUNCE_TICKS_RST);
            cfg_lp_en = mbdlp_pkg::LONG_PRESS_ENABLE_RST;
            cfg_lp    = 32'(mbdlp_pkg::LONG_PRESS_TICKS_RST);
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mbdlp_pkg::REG_SCAN_ENABLE:       cfg_scan  = i_cfg_data[0];
                    mbdlp_pkg::REG_DEBOUNCE_TICKS:    cfg_db    = 32'(i_cfg_data);
                    mbdlp_pkg::REG_LONG_PRESS_ENABLE: cfg_lp_en = i_cfg_data[0];
                    mbdlp_pkg::REG_LONG_PRESS_TICKS:  cfg_lp    = 32'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                want = debounce_tick(i_raw_levels);
                if (pin_valid) begin
                    want = pin_res;
                end
                tick_reports_q.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                press_count += $countones(o_press_pulses);
                long_count  += $countones(o_long_press_pulses);
                if (tick_reports_q.size() == 0) begin
                    $error("output word with nothing pending");
                    fails++;
                end else begin
                    want = tick_reports_q.pop_front();
                    if (o_press_pulses !== want.press) begin
                        $error("press_pulses: expected %b, got %b", want.press, o_press_pulses);
                        fails++;
                    end
                    if (o_long_press_pulses !== want.long_press) begin
                        $error("long_press_pulses: expected %b, got %b",
                               want.long_press, o_long_press_pulses);
                        fails++;
                    end
                    if (o_stable_levels !== want.levels) begin
                        $error("stable_levels: expected %b, got %b", want.levels, o_stable_levels);
                        fails++;
                    end
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // output side back-pressure
    initial begin : receiver
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_offs++;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [NB-1:0] raw, input logic pinned,
                             input t_tick_report rep);
        i_in_valid   <= 1'b1;
        i_raw_levels <= raw;
        pin_valid    <= pinned;
        pin_res      <= rep;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic sender_gap(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // register write once every word has come back
    task automatic write_reg(input logic [mbdlp_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != words_sent) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= mbdlp_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // input side: directed table, then random phases
    initial begin : sender
        logic [NB-1:0]                   raw;
        logic [NB-1:0]                   target;
        logic [mbdlp_pkg::CFG_IDX_W-1:0] idx;
        int                              run_left;
        int                              burst_left;
        bit                              noise_run;
        int                              phase;
        int                              k;
        int                              db_pick;
        int                              lp_pick;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_raw_levels <= '1;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= mbdlp_pkg::REG_SCAN_ENABLE;
        i_cfg_data   <= '0;
        pin_valid    <= 1'b0;
        pin_res      <= NO_REPORT;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                write_reg(dir_tab[r].idx, 32'(dir_tab[r].data));
            end else begin
                send_word(dir_tab[r].raw, dir_tab[r].pinned, dir_tab[r].report);
                if ($urandom_range(0, 3) == 0) begin
                    sender_gap($urandom_range(1, 19));
                end
            end
        end

        // random phases of held levels with bounce and noise
        run_left   = 0;
        burst_left = 0;
        noise_run  = 1'b0;
        target     = '1;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1) begin
                quiet = 1'b1;
            end
            case ($urandom_range(0, 7))
                0:       db_pick = 0;
                1:       db_pick = $urandom_range(5, 12);
                default: db_pick = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 7))
                0:       lp_pick = 0;
                1:       lp_pick = $urandom_range(25, 60);
                default: lp_pick = $urandom_range(1, 20);
            endcase
            write_reg(mbdlp_pkg::REG_SCAN_ENABLE, (phase == SCAN_OFF_PHASE) ? 0 : 1);
            write_reg(mbdlp_pkg::REG_DEBOUNCE_TICKS, db_pick);
            write_reg(mbdlp_pkg::REG_LONG_PRESS_ENABLE, ($urandom_range(0, 3) != 0) ? 1 : 0);
            write_reg(mbdlp_pkg::REG_LONG_PRESS_TICKS, lp_pick);

            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if (run_left == 0) begin
                    noise_run = ($urandom_range(0, 4) == 0);
                    target    = NB'($urandom);
                    run_left  = $urandom_range(1, 40);
                end
                raw = noise_run ? NB'($urandom) : target;
                if (!noise_run && $urandom_range(0, 9) == 0) begin
                    idx = mbdlp_pkg::CFG_IDX_W'($urandom_range(0, NB - 1));
                    raw[idx] = ~raw[idx];
                end
                run_left--;

                // long receiver hold-off while words keep coming
                if (phase == HOLD_OFF_PHASE && k == 10) begin
                    hold_off_req = 1'b1;
                    burst_left   = 24;
                end

                send_word(raw, 1'b0, NO_REPORT);

                if (burst_left > 0) begin
                    burst_left--;
                end else if (!quiet && $urandom_range(0, 50) == 0) begin
                    // mid-phase setting change, often below a running count
                    idx = mbdlp_pkg::CFG_IDX_W'($urandom_range(0, 3));
                    case (idx)
                        mbdlp_pkg::REG_SCAN_ENABLE: begin
                            write_reg(idx, ($urandom_range(0, 3) != 0) ? 1 : 0);
                        end
                        mbdlp_pkg::REG_DEBOUNCE_TICKS: begin
                            write_reg(idx, $urandom_range(0, 6));
                        end
                        mbdlp_pkg::REG_LONG_PRESS_ENABLE: begin
                            write_reg(idx, $urandom_range(0, 1));
                        end
                        default: begin
                            write_reg(idx, $urandom_range(0, 24));
                        end
                    endcase
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    sender_gap($urandom_range(1, 19));
                end
            end
        end

        // drain
        i_in_valid <= 1'b0;
        while (results_seen != words_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tick_reports_q.size() != 0) begin
            $error("%0d words never came back", tick_reports_q.size());
            fails++;
        end

        $display("covered %0d scan words over %0d register writes: %0d presses, %0d long presses",
                 words_sent, cfg_writes, press_count, long_count);
        $display("receiver hold-offs: %0d, mismatches: %0d", hold_offs, fails);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
